[hw/rtl/kprt_pkg.sv]
package kprt_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int DATA_W  = 32;
  localparam int RULE_W  = 3 * DATA_W;

  localparam logic [1:0] REQ_SET    = 2'd0;
  localparam logic [1:0] REQ_GET    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  localparam logic [1:0] CFG_DEF_CAPS  = 2'd0;
  localparam logic [1:0] CFG_DEF_QUOTA = 2'd1;
  localparam logic [1:0] CFG_DEF_PRIO  = 2'd2;

  localparam logic [DATA_W-1:0] RESET_DEF_CAPS  = 32'd0;
  localparam logic [DATA_W-1:0] RESET_DEF_QUOTA = 32'd1024;
  localparam logic [DATA_W-1:0] RESET_DEF_PRIO  = 32'd1;

  typedef struct packed {
    logic load_req;
    logic capture;
    logic act;
    logic load_out;
  } kprt_cmd_t;

endpackage

[hw/rtl/kprt_ram.sv]
module kprt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/kprt_datapath.sv]
module kprt_datapath import kprt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  kprt_cmd_t         cmd,
  input  logic [1:0]        req_type,
  input  logic [DATA_W-1:0] client_id,
  input  logic [DATA_W-1:0] cap_bits,
  input  logic [DATA_W-1:0] quota_value,
  input  logic [DATA_W-1:0] prio_value,
  input  logic [DATA_W-1:0] wanted_caps,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [DATA_W-1:0] cfg_data,
  output logic [1:0]        status,
  output logic              rule_found,
  output logic [DATA_W-1:0] caps_out,
  output logic [DATA_W-1:0] quota_out,
  output logic [DATA_W-1:0] prio_out,
  output logic              has_all_caps
);

  logic [1:0]        req_r;
  logic [DATA_W-1:0] key_r;
  logic [DATA_W-1:0] caps_r;
  logic [DATA_W-1:0] quota_r;
  logic [DATA_W-1:0] prio_r;
  logic [DATA_W-1:0] want_r;

  logic [DATA_W-1:0] def_caps;
  logic [DATA_W-1:0] def_quota;
  logic [DATA_W-1:0] def_prio;

  logic [DATA_W-1:0] keys [ENTRIES];
  logic [ENTRIES-1:0] valid;
  logic [ENTRIES-1:0] match_vec;

  logic [IDX_W-1:0] hit_idx;
  logic             hit_any;
  logic [IDX_W-1:0] free_idx;
  logic             free_any;
  logic [IDX_W-1:0] slot;
  logic             set_we;

  logic [1:0] status_r;
  logic       found_r;

  logic [RULE_W-1:0] rule_rdata;
  logic [DATA_W-1:0] sel_caps;
  logic [DATA_W-1:0] sel_quota;
  logic [DATA_W-1:0] sel_prio;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r   <= req_type;
      key_r   <= client_id;
      caps_r  <= cap_bits;
      quota_r <= quota_value;
      prio_r  <= prio_value;
      want_r  <= wanted_caps;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      def_caps  <= RESET_DEF_CAPS;
      def_quota <= RESET_DEF_QUOTA;
      def_prio  <= RESET_DEF_PRIO;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEF_CAPS:  def_caps  <= cfg_data;
        CFG_DEF_QUOTA: def_quota <= cfg_data;
        CFG_DEF_PRIO:  def_prio  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int i = 0; i < ENTRIES; i++) begin
        match_vec[i] <= valid[i] && (keys[i] == key_r);
      end
    end
  end

  always_comb begin
    hit_idx  = '0;
    hit_any  = 1'b0;
    free_idx = '0;
    free_any = 1'b0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        hit_idx = IDX_W'(i);
        hit_any = 1'b1;
      end
      if (!valid[i]) begin
        free_idx = IDX_W'(i);
        free_any = 1'b1;
      end
    end
  end

  assign slot   = hit_any ? hit_idx : free_idx;
  assign set_we = cmd.act && (req_r == REQ_SET) && (hit_any || free_any);

  always_ff @(posedge clk) begin
    if (set_we) begin
      keys[slot] <= key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.act) begin
      if (set_we) begin
        valid[slot] <= 1'b1;
      end else if ((req_r == REQ_REMOVE) && hit_any) begin
        valid[hit_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.act) begin
      found_r <= hit_any;
      case (req_r)
        REQ_SET:    status_r <= (hit_any || free_any) ? ST_OK : ST_FULL;
        REQ_REMOVE: status_r <= hit_any ? ST_OK : ST_NOT_FOUND;
        REQ_GET:    status_r <= ST_OK;
        default:    status_r <= ST_OK;
      endcase
    end
  end

  kprt_ram #(
    .WIDTH (RULE_W),
    .DEPTH (ENTRIES)
  ) u_rule_ram (
    .clk   (clk),
    .we    (set_we),
    .waddr (slot),
    .wdata ({caps_r, quota_r, prio_r}),
    .raddr (hit_idx),
    .rdata (rule_rdata)
  );

  always_comb begin
    if (found_r) begin
      sel_caps  = rule_rdata[RULE_W-1 -: DATA_W];
      sel_quota = rule_rdata[2*DATA_W-1 -: DATA_W];
      sel_prio  = rule_rdata[DATA_W-1:0];
    end else begin
      sel_caps  = def_caps;
      sel_quota = def_quota;
      sel_prio  = def_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status <= status_r;
      if (req_r == REQ_GET) begin
        rule_found   <= found_r;
        caps_out     <= sel_caps;
        quota_out    <= sel_quota;
        prio_out     <= sel_prio;
        has_all_caps <= ((sel_caps & want_r) == want_r);
      end else if ((req_r == REQ_SET) || (req_r == REQ_REMOVE)) begin
        rule_found   <= found_r;
        caps_out     <= '0;
        quota_out    <= '0;
        prio_out     <= '0;
        has_all_caps <= 1'b0;
      end else begin
        rule_found   <= 1'b0;
        caps_out     <= '0;
        quota_out    <= '0;
        prio_out     <= '0;
        has_all_caps <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/kprt_ctrl.sv]
module kprt_ctrl import kprt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output kprt_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_ACT,
    S_DONE
  } state_t;

  state_t state;

  assign in_ready     = (state == S_IDLE);
  assign cmd.load_req = in_valid && in_ready;
  assign cmd.capture  = (state == S_MATCH);
  assign cmd.act      = (state == S_ACT);
  assign cmd.load_out = (state == S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.load_req) begin
            state <= S_MATCH;
          end
        end
        S_MATCH: begin
          state <= S_ACT;
        end
        S_ACT: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (cmd.load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/keyed_policy_rule_table_core.sv]
// Policy rule table keyed by client id, with configurable defaults for ids without a rule.
// Requests enter on the in_valid/in_ready channel and each one produces exactly one
// result item on the out_valid/out_ready channel. A set updates the matching rule or
// fills the lowest free slot, a get returns the rule or the defaults, and a remove
// clears the matching rule.
// From acceptance to its result an item goes through these steps in order: the request
// is registered, its key is compared against every stored key, the hit or free slot is
// picked and the rule memory accessed, and the output register is loaded. A new item is
// accepted only after the previous one has loaded its result into the output register.
// The result sits in an output register, so the block can accept the next item while
// a result still waits. A stalled receiver holds that result; a later item then waits
// in its final step until the output register is free.
// The default registers are written through the cfg channel, which is always ready.
// They should be written only while the block is idle.
// Synchronous reset clears every rule's valid mark and restores the defaults
// (caps 0, quota 1024, priority 1). There is no clearing pass after reset.
module keyed_policy_rule_table_core import kprt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        req_type,
  input  logic [DATA_W-1:0] client_id,
  input  logic [DATA_W-1:0] cap_bits,
  input  logic [DATA_W-1:0] quota_value,
  input  logic [DATA_W-1:0] prio_value,
  input  logic [DATA_W-1:0] wanted_caps,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic              rule_found,
  output logic [DATA_W-1:0] caps_out,
  output logic [DATA_W-1:0] quota_out,
  output logic [DATA_W-1:0] prio_out,
  output logic              has_all_caps,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [DATA_W-1:0] cfg_data
);

  kprt_cmd_t cmd;

  assign cfg_ready = 1'b1;

  kprt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  kprt_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .req_type     (req_type),
    .client_id    (client_id),
    .cap_bits     (cap_bits),
    .quota_value  (quota_value),
    .prio_value   (prio_value),
    .wanted_caps  (wanted_caps),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .status       (status),
    .rule_found   (rule_found),
    .caps_out     (caps_out),
    .quota_out    (quota_out),
    .prio_out     (prio_out),
    .has_all_caps (has_all_caps)
  );

endmodule
